FILE: rtl/nps_pkg.sv
// nearest point search: shared types and constants
// no dependencies

package nps_pkg;

   localparam int MaxPoints = 256;
   localparam int IdxW = $clog2(MaxPoints);
   localparam int CntW = IdxW + 1;

   localparam logic [1:0] FUNC_APPEND = 2'd0;
   localparam logic [1:0] FUNC_CLEAR  = 2'd1;
   localparam logic [1:0] FUNC_RADIUS = 2'd2;
   localparam logic [1:0] FUNC_PREC   = 2'd3;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [14:0]        sx;
      logic [14:0]        sy;
   } point_type;

   // query travelling along the cell chain
   typedef struct packed {
      logic               vld;
      logic               mode_radius;
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic               have;
      logic [33:0]        best;
      logic [IdxW-1:0]    best_i;
      logic [16:0]        best_ax;
      logic [16:0]        best_ay;
   } probe_type;

endpackage

FILE: rtl/nps_cell.sv
// nearest point search: one table cell, holds a point and compares a passing query
// depends on nps_pkg

module nps_cell
   import nps_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IdxW-1:0]  cell_idx,
   input  logic             wr_en,
   input  point_type        wr_pt,
   input  logic             occupied,
   input  probe_type        probe_in,
   output probe_type        probe_out
);

   point_type pt_ff;
   probe_type probe_ff, probe_in_c;
   logic [16:0] ax_ff, ay_ff;
   probe_type stage_ff;
   logic [14:0] r_ff;
   logic        occ_ff;
   logic signed [16:0] dx, dy;
   logic [16:0] ax, ay;
   logic [33:0] d2, r2;
   logic        qual;

   always_ff @(posedge clock) begin
      if (wr_en) pt_ff <= wr_pt;
   end

   // stage 1: offsets
   always_comb begin
      dx = 17'(pt_ff.x) - 17'(probe_in.qx);
      dy = 17'(pt_ff.y) - 17'(probe_in.qy);
      ax = dx[16] ? 17'(-dx) : 17'(dx);
      ay = dy[16] ? 17'(-dy) : 17'(dy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.vld <= 1'b0;
      end else begin
         stage_ff.vld <= probe_in.vld;
      end
      stage_ff[$bits(probe_type)-2:0] <= probe_in[$bits(probe_type)-2:0];
      ax_ff  <= ax;
      ay_ff  <= ay;
      r_ff   <= (pt_ff.sx > pt_ff.sy) ? pt_ff.sx : pt_ff.sy;
      occ_ff <= occupied;
   end

   // stage 2: squared distance, qualify, keep best
   always_comb begin
      d2 = 34'(ax_ff * ax_ff) + 34'(ay_ff * ay_ff);
      r2 = 34'(r_ff * r_ff);
      qual = occ_ff && (!stage_ff.mode_radius || r2 >= d2);
      probe_in_c = stage_ff;
      if (qual && (!stage_ff.have || d2 < stage_ff.best)) begin
         probe_in_c.have    = 1'b1;
         probe_in_c.best    = d2;
         probe_in_c.best_i  = cell_idx;
         probe_in_c.best_ax = ax_ff;
         probe_in_c.best_ay = ay_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.vld <= 1'b0;
      end else begin
         probe_ff.vld <= probe_in_c.vld;
      end
      probe_ff[$bits(probe_type)-2:0] <= probe_in_c[$bits(probe_type)-2:0];
   end

   assign probe_out = probe_ff;

endmodule

FILE: rtl/nearest_point_search_top.sv
// nearest point search top: control, cell chain and result register
// depends on nps_pkg and nps_cell
//
// One item at a time. Append and clear write their result straight into the
// output register. A query walks the chain of MaxPoints cells, two register
// stages per cell, and passes every cell no matter how many points are
// stored. Ties go to the lowest index. The result waits in an output
// register and the next item is taken once it has been passed on.

module nearest_point_search_top
   import nps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [14:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // func
   input  logic [63:0] req_tdata,   // point_x, point_y, spread_x, spread_y, 2'b0
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // found, match_index, table_full, 6'b0
);

   logic [14:0]     prec_ff;
   logic [CntW-1:0] count_ff;
   logic            busy_ff;
   logic            rv_ff;
   logic [9:0]      rd_ff;
   point_type       wpt;
   probe_type       chain [0:MaxPoints];
   probe_type       head;
   logic            acc, done, pfound;

   assign wpt.x  = req_tdata[15:0];
   assign wpt.y  = req_tdata[31:16];
   assign wpt.sx = req_tdata[46:32];
   assign wpt.sy = req_tdata[61:47];

   assign req_tready = !busy_ff && !rv_ff;
   assign acc = req_tvalid && req_tready;

   always_comb begin
      head = '0;
      head.vld = acc && (req_tuser == FUNC_RADIUS || req_tuser == FUNC_PREC);
      head.mode_radius = (req_tuser == FUNC_RADIUS);
      head.qx = wpt.x;
      head.qy = wpt.y;
   end
   assign chain[0] = head;

   genvar g;
   generate
      for (g = 0; g < MaxPoints; g++) begin : g_cell
         nps_cell u_cell (
            .clock(clock), .reset(reset),
            .cell_idx(IdxW'(g)),
            .wr_en(acc && req_tuser == FUNC_APPEND && count_ff == CntW'(g)),
            .wr_pt(wpt),
            .occupied(count_ff > CntW'(g)),
            .probe_in(chain[g]),
            .probe_out(chain[g+1])
         );
      end
   endgenerate

   assign done = chain[MaxPoints].vld;
   assign pfound = chain[MaxPoints].have && (chain[MaxPoints].mode_radius ||
      (chain[MaxPoints].best_ax < 17'(prec_ff) && chain[MaxPoints].best_ay < 17'(prec_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         prec_ff  <= 15'd16;
         count_ff <= '0;
         busy_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         if (csr_we) prec_ff <= csr_wdata;
         if (rv_ff && rsp_tready) rv_ff <= 1'b0;
         if (acc) begin
            case (req_tuser)
               FUNC_APPEND: begin
                  rv_ff <= 1'b1;
                  if (count_ff >= CntW'(MaxPoints)) begin
                     rd_ff <= {1'b1, 8'd0, 1'b0};
                  end else begin
                     rd_ff <= {1'b0, 8'(count_ff), 1'b1};
                     count_ff <= count_ff + 1'b1;
                  end
               end
               FUNC_CLEAR: begin
                  rv_ff <= 1'b1;
                  rd_ff <= '0;
                  count_ff <= '0;
               end
               default: busy_ff <= 1'b1;
            endcase
         end
         if (done) begin
            busy_ff <= 1'b0;
            rv_ff   <= 1'b1;
            rd_ff   <= pfound ? {1'b0, 8'(chain[MaxPoints].best_i), 1'b1} : '0;
         end
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {6'd0, rd_ff};

endmodule

FILE: test/tb_nearest_point_search_top.sv
// testbench for nearest_point_search_top: directed and random append/clear/query traffic
// checked against an in-bench predictor of the point table; depends on nps_pkg and the rtl

class nps_scoreboard;
   nps_pkg::point_type pts[nps_pkg::MaxPoints];
   int                 count;
   logic [14:0]        prec;
   logic [9:0]         due[64];   // {table_full, match_index, found}
   int                 due_wr, due_rd;
   int                 errors;

   function new();
      count  = 0;
      prec   = 15'd16;
      errors = 0;
      due_wr = 0;
      due_rd = 0;
   endfunction

   function int pending();
      return due_wr - due_rd;
   endfunction

   // work out the answer for one accepted transfer
   function void note_item(logic [1:0] func, logic signed [15:0] qx, logic signed [15:0] qy,
                           logic [14:0] sx, logic [14:0] sy);
      logic       hit;
      logic [7:0] idx;
      logic       full;
      longint     ax, ay, d2, r, best;
      int         besti;
      hit = 0; idx = 0; full = 0; best = 0; besti = 0;
      case (func)
         nps_pkg::FUNC_APPEND: begin
            if (count >= nps_pkg::MaxPoints) begin
               full = 1;
            end else begin
               pts[count] = '{x: qx, y: qy, sx: sx, sy: sy};
               idx = count[7:0];
               hit = 1;
               count++;
            end
         end
         nps_pkg::FUNC_CLEAR: count = 0;
         default: begin
            for (int g = 0; g < count; g++) begin
               ax = longint'(pts[g].x) - longint'(qx);
               ay = longint'(pts[g].y) - longint'(qy);
               if (ax < 0) ax = -ax;
               if (ay < 0) ay = -ay;
               d2 = ax * ax + ay * ay;
               if (func == nps_pkg::FUNC_RADIUS) begin
                  r = (pts[g].sx > pts[g].sy) ? pts[g].sx : pts[g].sy;
                  if (r * r < d2) continue;
               end
               if (!hit || d2 < best) begin
                  hit = 1; best = d2; besti = g;
               end
            end
            if (hit && func == nps_pkg::FUNC_PREC) begin
               ax = longint'(pts[besti].x) - longint'(qx);
               ay = longint'(pts[besti].y) - longint'(qy);
               if (ax < 0) ax = -ax;
               if (ay < 0) ay = -ay;
               if (ax >= prec || ay >= prec) hit = 0;
            end
            if (hit) idx = besti[7:0];
         end
      endcase
      due[due_wr % 64] = {full, idx, hit};
      due_wr++;
   endfunction

   function void check_result(logic [15:0] data);
      logic [9:0] want;
      if (due_wr == due_rd) begin
         errors++;
         if (errors <= 10) $display("unexpected result %h", data);
         return;
      end
      want = due[due_rd % 64];
      due_rd++;
      if (data[9:0] !== want) begin
         errors++;
         if (errors <= 10)
            $display("mismatch: found %b/%b index %0d/%0d full %b/%b (expected/actual)",
                     want[0], data[0], want[8:1], data[8:1], want[9], data[9]);
      end
   endfunction
endclass

module tb_nearest_point_search_top;
   import nps_pkg::*;

   localparam int ITEMS = 1700;
   localparam longint LIMIT = 4000000;

   logic        clock, reset;
   logic        csr_we;
   logic [14:0] csr_wdata;
   logic        req_tvalid, req_tready;
   logic [1:0]  req_tuser;      // func
   logic [63:0] req_tdata;      // point_x, point_y, spread_x, spread_y, 2'b0
   logic        rsp_tvalid, rsp_tready;
   logic [15:0] rsp_tdata;      // found, match_index, table_full, 6'b0

   nps_scoreboard table_model;
   longint cycles = 0;
   int     sent;
   int     burst;

   nearest_point_search_top dut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // monitor both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            table_model.note_item(req_tuser, req_tdata[15:0], req_tdata[31:16],
                                  req_tdata[46:32], req_tdata[61:47]);
         if (rsp_tvalid && rsp_tready)
            table_model.check_result(rsp_tdata);
      end
   end

   // receiver: switches between random stall patterns
   initial begin
      int mode, left, stall;
      bit held;
      rsp_tready = 0;
      mode = 0; left = 0; stall = 0; held = 0;
      forever begin
         @(negedge clock);
         if (!held && sent > 600) begin
            held = 1;
            rsp_tready = 0;
            repeat (3000) @(negedge clock);
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(50, 400);
         end
         left--;
         case (mode)
            0: rsp_tready = 1;
            1: rsp_tready = 1'($urandom_range(0, 1));
            2: rsp_tready = ($urandom_range(0, 3) == 0);
            default: begin
               if (stall > 0) begin
                  stall--; rsp_tready = 0;
               end else begin
                  rsp_tready = 1;
                  stall = $urandom_range(0, 20);
               end
            end
         endcase
      end
   end

   task automatic send(logic [1:0] func, logic signed [15:0] x, logic signed [15:0] y,
                       logic [14:0] sx, logic [14:0] sy);
      if (burst == 0) begin
         req_tvalid = 0;
         repeat ($urandom_range(0, 12)) @(negedge clock);
         burst = $urandom_range(1, 16);
      end
      burst--;
      req_tuser  = func;
      req_tdata  = {2'b0, sy, sx, y, x};
      req_tvalid = 1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent++;
   endtask

   task automatic set_precision(logic [14:0] v);
      req_tvalid = 0;
      while (table_model.pending() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      csr_we = 1; csr_wdata = v;
      @(negedge clock);
      csr_we = 0;
      table_model.prec = v;
   endtask

   function automatic logic [14:0] rand_spread();
      return ($urandom_range(0, 1)) ? 15'($urandom()) : 15'($urandom_range(0, 400));
   endfunction

   // query somewhere near a stored point, or anywhere
   task automatic query_near(logic [1:0] func);
      logic signed [15:0] x, y;
      int k;
      if (table_model.count > 0 && $urandom_range(0, 3) != 0) begin
         k = $urandom_range(0, table_model.count - 1);
         x = table_model.pts[k].x + 16'($signed($urandom_range(0, 80)) - 40);
         y = table_model.pts[k].y + 16'($signed($urandom_range(0, 80)) - 40);
      end else begin
         x = 16'($urandom()); y = 16'($urandom());
      end
      send(func, x, y, 15'($urandom()), 15'($urandom()));
   endtask

   initial begin
      int n, cx, cy;
      logic [14:0] pv;
      reset = 1; csr_we = 0; csr_wdata = 0;
      req_tvalid = 0; req_tuser = 0; req_tdata = 0;
      sent = 0; burst = 0;
      table_model = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: empty table, extremes, ties, radius edge, precision reject, clear
      send(FUNC_RADIUS, 0, 0, 15'h7fff, 15'h7fff);
      send(FUNC_PREC, 0, 0, 0, 0);
      send(FUNC_APPEND, 16'sh7fff, 16'sh7fff, 15'h7fff, 15'h7fff);
      send(FUNC_APPEND, -16'sh8000, -16'sh8000, 0, 0);
      send(FUNC_APPEND, 0, 0, 16, 3);
      send(FUNC_APPEND, 0, 0, 5, 0);
      send(FUNC_RADIUS, 0, 0, 0, 0);        // tie, lowest index
      send(FUNC_RADIUS, 0, 16, 0, 0);       // exactly on the radius
      send(FUNC_RADIUS, 1, 16, 0, 0);       // just outside
      send(FUNC_PREC, 15, 0, 0, 0);         // inside precision
      send(FUNC_PREC, 16, 0, 0, 0);         // offset equals precision
      send(FUNC_PREC, -16'sh8000, -16'sh8000, 15'h7fff, 15'h7fff);
      send(FUNC_RADIUS, 16'sh7fff, -16'sh8000, 0, 0);
      send(FUNC_PREC, 16'sh7fff, -16'sh8000, 0, 0);
      send(FUNC_CLEAR, 16'sh7fff, 16'sh7fff, 15'h7fff, 15'h7fff);
      send(FUNC_RADIUS, 0, 0, 0, 0);
      send(FUNC_PREC, 0, 0, 0, 0);

      // random phases: precision change, clear, appends, queries
      while (sent < ITEMS) begin
         case ($urandom_range(0, 5))
            0: pv = 0;
            1: pv = 15'h7fff;
            2: pv = 16;
            default: pv = $urandom_range(0, 1) ? 15'($urandom()) : 15'($urandom_range(1, 200));
         endcase
         if ($urandom_range(0, 2) == 0) set_precision(pv);
         if ($urandom_range(0, 3) == 0) send(FUNC_CLEAR, 16'($urandom()), 16'($urandom()),
                                            15'($urandom()), 15'($urandom()));
         n = ($urandom_range(0, 15) == 0) ? 260 : $urandom_range(1, 12);
         cx = $signed(16'($urandom())); cy = $signed(16'($urandom()));
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1))
               send(FUNC_APPEND, 16'(cx + $urandom_range(0, 200)), 16'(cy + $urandom_range(0, 200)),
                    rand_spread(), rand_spread());
            else
               send(FUNC_APPEND, 16'($urandom()), 16'($urandom()), rand_spread(), rand_spread());
         end
         repeat ($urandom_range(1, 6))
            query_near($urandom_range(0, 1) ? FUNC_RADIUS : FUNC_PREC);
      end

      req_tvalid = 0;
      while (table_model.pending() != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      if (table_model.errors == 0 && table_model.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
